// ----- hw/rtl/dbp_pkg.sv -----
// Shared types, constants and helpers of the depth pixel back-projection block.
// No dependencies; all other files refer to it by scoped names.
package dbp_pkg;

	localparam int MAX_RECTS = 16;
	localparam int STRIDE = 3;
	localparam int CNT_W = $clog2(MAX_RECTS + 1);
	localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int QUEUE_DEPTH = 2;

	// Depth window in Q3.13: 0.01 m and 5 m
	localparam logic [15:0] DEPTH_MIN = 16'd82;
	localparam logic [15:0] DEPTH_MAX = 16'd40960;

	// Reciprocal for the stride remainder test on 12-bit positions
	localparam int STRIDE_SH = 16;
	localparam int STRIDE_RECIP = (1 << STRIDE_SH) / STRIDE + 1;

	localparam logic [15:0] CX_RESET = 16'd5120;
	localparam logic [15:0] CY_RESET = 16'd3840;
	localparam logic [15:0] FX_RESET = 16'd8240;
	localparam logic [15:0] FY_RESET = 16'd8240;

	localparam logic [19:0] OUT_POS_MAX = 20'h7FFFF;
	localparam logic [19:0] OUT_NEG_MAX = 20'h80000;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_RECT  = 2'd1,
		KIND_PIXEL = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_CX = 2'd0,
		REG_CY = 2'd1,
		REG_FX = 2'd2,
		REG_FY = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCAN,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_SAT,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] width;
		logic [11:0] height;
	} rect_t;

	typedef struct packed {
		logic [11:0] col;
		logic [11:0] row;
		logic [15:0] depth;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} pix_t;

	typedef struct packed {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] fx;
		logic [15:0] fy;
	} cfg_t;

	typedef struct packed {
		logic             idle;
		logic [CNT_W-1:0] rect_count;
	} fstat_t;

	// True when v is a multiple of STRIDE
	function automatic logic stride_ok(logic [11:0] v);
		logic [29:0] p;
		logic [11:0] q;
		p = 30'(v) * 30'(STRIDE_RECIP);
		q = p[STRIDE_SH +: 12];
		return v == 12'(32'(q) * STRIDE);
	endfunction

	// Half-open rectangle hit test
	function automatic logic in_rect(rect_t r, logic [11:0] c, logic [11:0] rw);
		logic [12:0] re;
		logic [12:0] be;
		re = {1'b0, r.left} + {1'b0, r.width};
		be = {1'b0, r.top} + {1'b0, r.height};
		return (c >= r.left) && ({1'b0, c} < re) && (rw >= r.top) && ({1'b0, rw} < be);
	endfunction

	// One restoring division step: {remainder, shifted quotient}
	function automatic logic [47:0] div_step(logic [15:0] rem, logic [31:0] q,
			logic [15:0] d);
		logic [16:0] t;
		logic        ge;
		t = {rem, q[31]};
		ge = t >= {1'b0, d};
		if (ge) begin
			t = t - {1'b0, d};
		end
		return {t[15:0], q[30:0], ge};
	endfunction

	// Apply sign and clamp to signed Q6.13
	function automatic logic [19:0] sat_out(logic [31:0] q, logic neg);
		logic [19:0] r;
		if (neg) begin
			r = (q > 32'd524288) ? OUT_NEG_MAX : 20'(~q + 32'd1);
		end else begin
			r = (q > 32'd524287) ? OUT_POS_MAX : q[19:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/dbp_front.sv -----
// Front end: accepts transactions, keeps the exclusion rectangles, filters pixels.
// Depends on dbp_pkg.
module dbp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [11:0]         rect_left,
	input  logic [11:0]         rect_top,
	input  logic [11:0]         rect_width,
	input  logic [11:0]         rect_height,
	input  logic [11:0]         col,
	input  logic [11:0]         row,
	input  logic [15:0]         depth_value,
	input  logic                mask_nonzero,
	input  logic [7:0]          blue,
	input  logic [7:0]          green,
	input  logic [7:0]          red,
	output logic                push_valid,
	input  logic                push_ready,
	output dbp_pkg::pix_t       push_data,
	output dbp_pkg::fstat_t     stat
);

	dbp_pkg::front_state_t state_q, state_d;
	logic [dbp_pkg::CNT_W-1:0] count_q;
	logic [dbp_pkg::CNT_W-1:0] idx_q;
	logic                      rdv_q;
	logic                      last_q;
	dbp_pkg::rect_t            rd_q;
	dbp_pkg::rect_t            mem [dbp_pkg::MAX_RECTS];
	dbp_pkg::pix_t             pix_q;
	logic                      mask_q;

	logic accept;
	logic is_pixel;
	logic add_ok;
	logic keep;
	logic hit;

	assign accept   = in_valid && in_ready;
	assign is_pixel = kind == dbp_pkg::KIND_PIXEL;
	assign add_ok   = (kind == dbp_pkg::KIND_RECT)
		&& (count_q < dbp_pkg::CNT_W'(dbp_pkg::MAX_RECTS));
	assign keep     = dbp_pkg::stride_ok(col) && dbp_pkg::stride_ok(row)
		&& (depth_value >= dbp_pkg::DEPTH_MIN) && (depth_value <= dbp_pkg::DEPTH_MAX);
	assign hit      = rdv_q && dbp_pkg::in_rect(rd_q, pix_q.col, pix_q.row);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dbp_pkg::F_IDLE: begin
				if (accept && is_pixel && keep) begin
					if (mask_nonzero && (count_q != '0)) begin
						state_d = dbp_pkg::F_SCAN;
					end else begin
						state_d = dbp_pkg::F_PUSH;
					end
				end
			end
			dbp_pkg::F_SCAN: begin
				if (hit) begin
					state_d = dbp_pkg::F_IDLE;
				end else if (rdv_q && last_q) begin
					state_d = dbp_pkg::F_PUSH;
				end
			end
			dbp_pkg::F_PUSH: begin
				if (push_ready) begin
					state_d = dbp_pkg::F_IDLE;
				end
			end
			default: state_d = dbp_pkg::F_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			dbp_pkg::F_IDLE: in_ready = 1'b1;
			dbp_pkg::F_PUSH: push_valid = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbp_pkg::F_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (kind == dbp_pkg::KIND_CLEAR) begin
					count_q <= '0;
				end else if (add_ok) begin
					count_q <= count_q + 1'b1;
				end
				if (is_pixel) begin
					idx_q <= '0;
					rdv_q <= 1'b0;
				end
			end
			// Walk the stored rectangles one a cycle
			if (state_q == dbp_pkg::F_SCAN) begin
				if (idx_q < count_q) begin
					idx_q <= idx_q + 1'b1;
					rdv_q <= 1'b1;
				end else begin
					rdv_q <= 1'b0;
				end
			end
		end
	end

	// Rectangle store and pixel hold
	always_ff @(posedge clk) begin
		if (accept && add_ok) begin
			mem[count_q[dbp_pkg::IDX_W-1:0]] <= '{rect_left, rect_top, rect_width, rect_height};
		end
		if (state_q == dbp_pkg::F_SCAN) begin
			rd_q   <= mem[idx_q[dbp_pkg::IDX_W-1:0]];
			last_q <= idx_q == (count_q - 1'b1);
		end
		if (accept && is_pixel) begin
			pix_q  <= '{col, row, depth_value, blue, green, red};
			mask_q <= mask_nonzero;
		end
	end

	assign push_data       = pix_q;
	assign stat.idle       = (state_q == dbp_pkg::F_IDLE) && !mask_q | (state_q == dbp_pkg::F_IDLE);
	assign stat.rect_count = count_q;

endmodule

// ----- hw/rtl/dbp_queue.sv -----
// Two-entry queue of kept pixels between the front and back ends.
// Depends on dbp_pkg.
module dbp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  dbp_pkg::pix_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output dbp_pkg::pix_t pop_data,
	output logic [1:0]    level
);

	dbp_pkg::pix_t ent_q [dbp_pkg::QUEUE_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] lvl_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = lvl_q != 2'(dbp_pkg::QUEUE_DEPTH);
	assign pop_valid  = lvl_q != 2'd0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = ent_q[rd_q];
	assign level      = lvl_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			lvl_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				lvl_q <= lvl_q + 2'd1;
			end else if (do_pop && !do_push) begin
				lvl_q <= lvl_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/dbp_back.sv -----
// Back end: pinhole back-projection with two bit-serial dividers and saturation.
// Depends on dbp_pkg.
module dbp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dbp_pkg::cfg_t       cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  dbp_pkg::pix_t       pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [19:0]  point_x,
	output logic signed [19:0]  point_y,
	output logic [15:0]         point_z,
	output logic [7:0]          out_blue,
	output logic [7:0]          out_green,
	output logic [7:0]          out_red
);

	dbp_pkg::back_state_t state_q, state_d;
	logic [4:0]    cnt_q;
	dbp_pkg::pix_t pix_q;
	logic          negx_q, negy_q;
	logic [31:0]   qx_q, qy_q;
	logic [15:0]   rx_q, ry_q;
	logic [15:0]   fx_q, fy_q;
	logic [19:0]   px_q, py_q;

	logic signed [17:0] dx, dy;
	logic [15:0]        mx, my;
	logic [47:0]        stx, sty;

	// Offsets from the principal point in Q.4
	assign dx  = $signed({2'b00, pix_q.col, 4'b0000}) - $signed({2'b00, cfg.cx});
	assign dy  = $signed({2'b00, pix_q.row, 4'b0000}) - $signed({2'b00, cfg.cy});
	assign mx  = dx[17] ? 16'(-dx) : dx[15:0];
	assign my  = dy[17] ? 16'(-dy) : dy[15:0];
	assign stx = dbp_pkg::div_step(rx_q, qx_q, fx_q);
	assign sty = dbp_pkg::div_step(ry_q, qy_q, fy_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dbp_pkg::B_IDLE: if (pop_valid) state_d = dbp_pkg::B_MUL;
			dbp_pkg::B_MUL:  state_d = dbp_pkg::B_DIV;
			dbp_pkg::B_DIV:  if (cnt_q == 5'd0) state_d = dbp_pkg::B_SAT;
			dbp_pkg::B_SAT:  state_d = dbp_pkg::B_OUT;
			dbp_pkg::B_OUT:  if (out_ready) state_d = dbp_pkg::B_IDLE;
			default:         state_d = dbp_pkg::B_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			dbp_pkg::B_IDLE: pop_ready = 1'b1;
			dbp_pkg::B_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbp_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			dbp_pkg::B_IDLE: begin
				pix_q <= pop_data;
			end
			dbp_pkg::B_MUL: begin
				qx_q   <= 32'(mx) * 32'(pix_q.depth);
				qy_q   <= 32'(my) * 32'(pix_q.depth);
				negx_q <= dx[17];
				negy_q <= dy[17];
				rx_q   <= '0;
				ry_q   <= '0;
				cnt_q  <= 5'd31;
				fx_q   <= (cfg.fx == 16'd0) ? 16'd1 : cfg.fx;
				fy_q   <= (cfg.fy == 16'd0) ? 16'd1 : cfg.fy;
			end
			dbp_pkg::B_DIV: begin
				{rx_q, qx_q} <= stx;
				{ry_q, qy_q} <= sty;
				cnt_q        <= cnt_q - 5'd1;
			end
			dbp_pkg::B_SAT: begin
				px_q <= dbp_pkg::sat_out(qx_q, negx_q);
				py_q <= dbp_pkg::sat_out(qy_q, negy_q);
			end
			default: ;
		endcase
	end

	assign point_x   = $signed(px_q);
	assign point_y   = $signed(py_q);
	assign point_z   = pix_q.depth;
	assign out_blue  = pix_q.blue;
	assign out_green = pix_q.green;
	assign out_red   = pix_q.red;

endmodule

// ----- hw/rtl/depth_pixel_backprojection_top.sv -----
// Top level: APB register file, front end, pixel queue and back end.
// Depends on dbp_pkg, dbp_front, dbp_queue, dbp_back.
//
// A command is taken while the front end is idle and leaves it idle. A pixel off the stride
// grid or outside the depth window is dropped on acceptance. A kept pixel without the mask
// bit, or with no rectangles stored, is accepted and then handed to the queue, waiting
// while the queue is full. A masked pixel is tested against the stored rectangles one per
// cycle through the single read port of the rectangle store; a hit drops it. The back end
// handles each kept pixel in turn (pop, multiply, 32 steps of the radix-2 dividers for x
// and y in parallel, clamp, output register) and takes no new pixel until its result has
// been taken at the output; a two-entry queue lets the front end keep filtering while the
// back end divides.
module depth_pixel_backprojection_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [11:0]        rect_left,
	input  logic [11:0]        rect_top,
	input  logic [11:0]        rect_width,
	input  logic [11:0]        rect_height,
	input  logic [11:0]        col,
	input  logic [11:0]        row,
	input  logic [15:0]        depth_value,
	input  logic               mask_nonzero,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [19:0] point_x,
	output logic signed [19:0] point_y,
	output logic [15:0]        point_z,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_green,
	output logic [7:0]         out_red
);

	dbp_pkg::cfg_t   cfg_q;
	dbp_pkg::fstat_t fstat;
	dbp_pkg::pix_t   push_data, pop_data;
	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [1:0]      q_level;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cx <= dbp_pkg::CX_RESET;
			cfg_q.cy <= dbp_pkg::CY_RESET;
			cfg_q.fx <= dbp_pkg::FX_RESET;
			cfg_q.fy <= dbp_pkg::FY_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				dbp_pkg::REG_CX: cfg_q.cx <= pwdata[15:0];
				dbp_pkg::REG_CY: cfg_q.cy <= pwdata[15:0];
				dbp_pkg::REG_FX: cfg_q.fx <= pwdata[15:0];
				dbp_pkg::REG_FY: cfg_q.fy <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr[3:2])
			dbp_pkg::REG_CX: prdata = {16'd0, cfg_q.cx};
			dbp_pkg::REG_CY: prdata = {16'd0, cfg_q.cy};
			dbp_pkg::REG_FX: prdata = {16'd0, cfg_q.fx};
			dbp_pkg::REG_FY: prdata = {16'd0, cfg_q.fy};
			default:         prdata = 32'd0;
		endcase
	end

	dbp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .kind,
		.rect_left, .rect_top, .rect_width, .rect_height,
		.col, .row, .depth_value, .mask_nonzero, .blue, .green, .red,
		.push_valid, .push_ready, .push_data, .stat(fstat)
	);

	dbp_queue u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_data,
		.pop_valid, .pop_ready, .pop_data, .level(q_level)
	);

	dbp_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .pop_valid, .pop_ready, .pop_data,
		.out_valid, .out_ready, .point_x, .point_y, .point_z,
		.out_blue, .out_green, .out_red
	);

	// Rectangle count never passes the store size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.rect_count <= dbp_pkg::CNT_W'(dbp_pkg::MAX_RECTS))
		else $error("rectangle count overflow");

	// Queue never overfills
	a_queue_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= 2'(dbp_pkg::QUEUE_DEPTH))
		else $error("queue overflow");

	// A clear command empties the store
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == dbp_pkg::KIND_CLEAR) |=> fstat.rect_count == '0)
		else $error("clear did not empty rectangles");

	// The front end only takes input while idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> fstat.idle)
		else $error("front end busy but ready");

endmodule
